// ----- src/i2cseq_pkg.sv -----
// i2cseq_pkg: shared types and constants of the i2c master bit sequencer
// op codes, internal command classes and the queue entry format
// no dependencies
`default_nettype none

package i2cseq_pkg;

  localparam int QueueDepth = 2;

  localparam logic [2:0] OP_START     = 3'd0;
  localparam logic [2:0] OP_STOP      = 3'd1;
  localparam logic [2:0] OP_SEND_BYTE = 3'd2;
  localparam logic [2:0] OP_RECV_BYTE = 3'd3;
  localparam logic [2:0] OP_SEND_ACK  = 3'd4;
  localparam logic [2:0] OP_RECV_ACK  = 3'd5;

  typedef enum logic [2:0] {
    CMD_START,
    CMD_STOP,
    CMD_SEND_BYTE,
    CMD_RECV_BYTE,
    CMD_SEND_ACK,
    CMD_RECV_ACK
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
    logic       bit_val;
  } cmd_entry_t;

  typedef struct packed {
    logic       is_sda;
    logic       level;
    logic       last;
    logic [1:0] phase_next;
    logic [2:0] idx_next;
  } step_t;

endpackage

`default_nettype wire

// ----- src/i2cseq_front.sv -----
// i2cseq_front: takes in commands, drops unused op codes and packs the rest
// into queue entries
// depends on i2cseq_pkg
`default_nettype none

module i2cseq_front (
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [2:0]             op,
  input  wire logic [7:0]             tx_byte,
  input  wire logic                   ack_out,
  input  wire logic [7:0]             slave_byte,
  input  wire logic                   slave_ack,
  input  wire logic                   q_ready,
  output logic                        q_push,
  output i2cseq_pkg::cmd_entry_t      q_entry
);

  logic op_ok;

  always_comb begin
    op_ok           = 1'b1;
    q_entry.cmd     = i2cseq_pkg::CMD_START;
    q_entry.data    = 8'd0;
    q_entry.bit_val = 1'b0;
    unique case (op)
      i2cseq_pkg::OP_START: begin
        q_entry.cmd = i2cseq_pkg::CMD_START;
      end
      i2cseq_pkg::OP_STOP: begin
        q_entry.cmd = i2cseq_pkg::CMD_STOP;
      end
      i2cseq_pkg::OP_SEND_BYTE: begin
        q_entry.cmd  = i2cseq_pkg::CMD_SEND_BYTE;
        q_entry.data = tx_byte;
      end
      i2cseq_pkg::OP_RECV_BYTE: begin
        q_entry.cmd  = i2cseq_pkg::CMD_RECV_BYTE;
        q_entry.data = slave_byte;
      end
      i2cseq_pkg::OP_SEND_ACK: begin
        q_entry.cmd     = i2cseq_pkg::CMD_SEND_ACK;
        q_entry.bit_val = ack_out;
      end
      i2cseq_pkg::OP_RECV_ACK: begin
        q_entry.cmd     = i2cseq_pkg::CMD_RECV_ACK;
        q_entry.bit_val = slave_ack;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
  end

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready && op_ok;

endmodule

`default_nettype wire

// ----- src/i2cseq_fifo.sv -----
// i2cseq_fifo: short command queue in flip-flops between front and back
// depends on i2cseq_pkg
`default_nettype none

module i2cseq_fifo #(
  parameter int DEPTH = i2cseq_pkg::QueueDepth
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire i2cseq_pkg::cmd_entry_t push_entry,
  output logic                        not_full,
  input  wire logic                   pop,
  output logic                        not_empty,
  output i2cseq_pkg::cmd_entry_t      head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  i2cseq_pkg::cmd_entry_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign not_full  = (count != CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> not_full)
    else $error("queue pushed while full");
`endif

endmodule

`default_nettype wire

// ----- src/i2cseq_back.sv -----
// i2cseq_back: walks each queued command through its pin steps, one per cycle
// when not stalled, keeps the bus drive levels and holds the registered result
// depends on i2cseq_pkg
`default_nettype none

module i2cseq_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_valid,
  input  wire i2cseq_pkg::cmd_entry_t q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        scl_level,
  output logic                        sda_level,
  output logic [7:0]                  rx_byte,
  output logic                        rx_ack,
  output logic                        last
);

  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_C = 2'd2;

  logic                   busy;
  logic                   busy_next;
  i2cseq_pkg::cmd_entry_t cur;
  i2cseq_pkg::cmd_entry_t act;
  logic [1:0]             phase;
  logic [2:0]             idx;
  logic                   scl_drive;
  logic                   sda_drive;
  logic                   scl_new;
  logic                   sda_new;
  logic                   advance;
  logic                   active;
  logic                   emit;
  i2cseq_pkg::step_t      step;

  assign act     = busy ? cur : q_head;
  assign active  = busy || q_valid;
  assign advance = !out_valid || out_ready;
  assign emit    = advance && active;
  assign q_pop   = emit && !busy;

  always_comb begin
    step.is_sda     = 1'b0;
    step.level      = 1'b0;
    step.last       = 1'b0;
    step.phase_next = phase + 1'b1;
    step.idx_next   = idx;
    unique case (act.cmd)
      i2cseq_pkg::CMD_START: begin
        case (phase)
          PH_A:    begin step.is_sda = 1'b1; step.level = 1'b1; end
          PH_B:    begin step.is_sda = 1'b0; step.level = 1'b1; end
          PH_C:    begin step.is_sda = 1'b1; step.level = 1'b0; end
          default: begin step.last = 1'b1; end
        endcase
      end
      i2cseq_pkg::CMD_STOP: begin
        case (phase)
          PH_A:    begin step.is_sda = 1'b1; step.level = 1'b0; end
          PH_B:    begin step.is_sda = 1'b0; step.level = 1'b1; end
          default: begin step.is_sda = 1'b1; step.level = 1'b1; step.last = 1'b1; end
        endcase
      end
      i2cseq_pkg::CMD_SEND_BYTE, i2cseq_pkg::CMD_RECV_BYTE: begin
        case (phase)
          PH_A: begin
            step.is_sda = 1'b1;
            step.level  = (act.cmd == i2cseq_pkg::CMD_SEND_BYTE) ? act.data[~idx] : 1'b1;
          end
          PH_B: begin
            step.level = 1'b1;
          end
          default: begin
            step.last     = (idx == 3'd7);
            step.idx_next = idx + 1'b1;
            step.phase_next = (act.cmd == i2cseq_pkg::CMD_SEND_BYTE) ? PH_A : PH_B;
          end
        endcase
      end
      default: begin
        case (phase)
          PH_A: begin
            step.is_sda = 1'b1;
            step.level  = (act.cmd == i2cseq_pkg::CMD_SEND_ACK) ? act.bit_val : 1'b1;
          end
          PH_B:    begin step.level = 1'b1; end
          default: begin step.last = 1'b1; end
        endcase
      end
    endcase
  end

  assign scl_new   = step.is_sda ? scl_drive : step.level;
  assign sda_new   = step.is_sda ? step.level : sda_drive;
  assign busy_next = emit ? !step.last : busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      phase     <= PH_A;
      idx       <= 3'd0;
      scl_drive <= 1'b1;
      sda_drive <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      busy <= busy_next;
      if (emit) begin
        scl_drive <= scl_new;
        sda_drive <= sda_new;
        phase     <= step.last ? PH_A : step.phase_next;
        idx       <= step.last ? 3'd0 : step.idx_next;
      end
      if (advance) begin
        out_valid <= active;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (emit) begin
      scl_level <= scl_new;
      sda_level <= sda_new;
      last      <= step.last;
      rx_byte   <= (step.last && act.cmd == i2cseq_pkg::CMD_RECV_BYTE) ? act.data : 8'd0;
      rx_ack    <= step.last && act.cmd == i2cseq_pkg::CMD_RECV_ACK && act.bit_val;
    end
  end

`ifndef ASSERT_OFF
  a_idle_counters: assert property (@(posedge clk) disable iff (rst)
      !busy |-> (phase == PH_A && idx == 3'd0))
    else $error("step counters not cleared between transactions");
  a_scl_low_at_end: assert property (@(posedge clk) disable iff (rst)
      emit && step.last && act.cmd != i2cseq_pkg::CMD_STOP |-> !scl_new)
    else $error("command ended with scl released");
  a_rx_only_last: assert property (@(posedge clk) disable iff (rst)
      out_valid && (rx_byte != 8'd0 || rx_ack) |-> last)
    else $error("received data shown before the final step");
  a_stop_releases: assert property (@(posedge clk) disable iff (rst)
      emit && step.last && act.cmd == i2cseq_pkg::CMD_STOP |=> (scl_drive && sda_drive))
    else $error("bus not idle after stop");
`endif

endmodule

`default_nettype wire

// ----- src/i2c_master_bit_sequencer_top.sv -----
// i2c_master_bit_sequencer_top: i2c master bus-phase sequencer, one pin step per result
// a command is written into the queue, then its steps into the back end output register
// throughput: one step per cycle while the output is not stalled by out_ready
// reset: scl and sda drive levels go high (bus idle), command queue empties
// depends on i2cseq_pkg, i2cseq_front, i2cseq_fifo, i2cseq_back
`default_nettype none

module i2c_master_bit_sequencer_top #(
  parameter int QUEUE_DEPTH = i2cseq_pkg::QueueDepth
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] op,
  input  wire logic [7:0] tx_byte,
  input  wire logic       ack_out,
  input  wire logic [7:0] slave_byte,
  input  wire logic       slave_ack,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            scl_level,
  output logic            sda_level,
  output logic [7:0]      rx_byte,
  output logic            rx_ack,
  output logic            last
);

  logic                   q_push;
  logic                   q_pop;
  logic                   q_not_full;
  logic                   q_not_empty;
  i2cseq_pkg::cmd_entry_t q_in;
  i2cseq_pkg::cmd_entry_t q_head;

  i2cseq_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .tx_byte    (tx_byte),
    .ack_out    (ack_out),
    .slave_byte (slave_byte),
    .slave_ack  (slave_ack),
    .q_ready    (q_not_full),
    .q_push     (q_push),
    .q_entry    (q_in)
  );

  i2cseq_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .not_full   (q_not_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  i2cseq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_not_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .scl_level (scl_level),
    .sda_level (sda_level),
    .rx_byte   (rx_byte),
    .rx_ack    (rx_ack),
    .last      (last)
  );

endmodule

`default_nettype wire
